// File: sv/gif_lzw_decoder_assert.svh
// ----------------------------------------------------------------------------
// GIF LZW decoder assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef GIF_LZW_DECODER_ASSERT_SVH
`define GIF_LZW_DECODER_ASSERT_SVH

`ifndef SYNTHESIS
// Checked outside reset.
`define GLD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("gif_lzw_decoder assertion failed");
// Checked at every edge, reset included.
`define GLD_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("gif_lzw_decoder assertion failed");
`else
`define GLD_ASSERT(lbl, clk, rstn, prop)
`define GLD_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// File: sv/gld_pkg.sv
// ----------------------------------------------------------------------------
// GIF LZW decoder package
// Shared widths, request and status codes, and bit unpacker control types.
// ----------------------------------------------------------------------------
package gld_pkg;

  localparam int CODE_W = 12;
  localparam int BUF_W  = 19;
  localparam int CNT_W  = 5;
  localparam int NEXT_W = 13;
  localparam int WID_W  = 4;

  localparam logic [1:0] OP_FEED  = 2'd0;
  localparam logic [1:0] OP_PULL  = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;

  localparam logic [2:0] ST_OK   = 3'd0;
  localparam logic [2:0] ST_BUSY = 3'd1;
  localparam logic [2:0] ST_MORE = 3'd2;
  localparam logic [2:0] ST_DONE = 3'd3;
  localparam logic [2:0] ST_ERR  = 3'd4;

  localparam logic [NEXT_W-1:0] PREV_NONE = 13'h1FFF;
  localparam logic [3:0]        MCS_RESET = 4'd8;

  typedef struct packed {
    logic clear;
    logic feed;
    logic consume;
  } bb_ctrl_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              has_code;
  } bb_stat_t;

endpackage

// File: sv/gld_bit_unpack.sv
// ----------------------------------------------------------------------------
// GIF LZW bit unpacker
// Packs compressed bytes LSB first and hands out variable-width codes.
// ----------------------------------------------------------------------------
module gld_bit_unpack (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gld_pkg::bb_ctrl_t ctrl_i,
  input  logic [7:0]        byte_i,
  input  logic [3:0]        width_i,
  output gld_pkg::bb_stat_t stat_o
);
  import gld_pkg::*;

  logic [BUF_W-1:0]  buf_q, buf_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [CODE_W-1:0] mask;

  assign mask            = ~({CODE_W{1'b1}} << width_i);
  assign stat_o.code     = buf_q[CODE_W-1:0] & mask;
  assign stat_o.has_code = cnt_q >= CNT_W'(width_i);

  always_comb begin
    buf_d = buf_q;
    cnt_d = cnt_q;
    if (ctrl_i.clear) begin
      buf_d = '0;
      cnt_d = '0;
    end else if (ctrl_i.feed) begin
      buf_d = buf_q | (BUF_W'(byte_i) << cnt_q);
      cnt_d = cnt_q + CNT_W'(8);
    end else if (ctrl_i.consume) begin
      buf_d = buf_q >> width_i;
      cnt_d = cnt_q - CNT_W'(width_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q <= '0;
      cnt_q <= '0;
    end else begin
      buf_q <= buf_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// File: sv/gif_lzw_decoder.sv
// ----------------------------------------------------------------------------
// GIF LZW decoder
// Variable-width LZW decoder with dictionary and string stack in block RAM.
// ----------------------------------------------------------------------------
// Usage: each slave request carries an op in tuser (feed byte, pull byte,
// start stream) and a compressed byte in tdata. Every request yields one
// response on the master side: tuser holds status and a byte-valid flag,
// tdata the decoded byte. The register port sets the GIF minimum code size;
// write it only between streams.
// Flow: feed, start and pulls answered from the done or error flag are
// answered from the idle state; pops from a loaded stack pass through S_POP. A
// pull that decodes a code walks the string through the dictionary RAM at
// one byte per cycle, passing S_DEC, S_WI (and S_WD for dictionary entries),
// S_FIN and S_POP, and stays in S_DEC while it consumes clear codes. A pull
// short of a whole code, or one that meets the end code or an error, answers from S_DEC.
// The dictionary RAM read-to-next-read loop sets the walk speed.
// One request is in flight at a time; a new one is taken once the output
// register is empty or being drained. A stalled receiver holds the response
// and blocks new requests. Reset (or a start request) empties the bit
// buffer and stack, clears done and error, and restarts the dictionary.
// ----------------------------------------------------------------------------
module gif_lzw_decoder #(
  parameter int DICT_ENTRIES  = 4096,
  parameter int MAX_CODE_BITS = 12
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_wdata_i,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic [1:0] s_axis_tuser,   // [1:0] op
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic [3:0] m_axis_tuser    // [2:0] status, [3] out_valid
);
  import gld_pkg::*;
  `include "gif_lzw_decoder_assert.svh"

  localparam int AW = $clog2(DICT_ENTRIES);
  localparam int PW = AW + 1;
  localparam logic [NEXT_W-1:0] DICT_N = NEXT_W'(DICT_ENTRIES);
  localparam logic [PW-1:0]     DICT_P = PW'(DICT_ENTRIES);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_WI   = 3'd2;
  localparam logic [2:0] S_WD   = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;
  localparam logic [2:0] S_POP  = 3'd5;

  logic [3:0]        mcs_q;
  logic [2:0]        state_q, state_d;
  logic [PW-1:0]     stk_cnt_q, stk_cnt_d;
  logic [NEXT_W-1:0] next_q, next_d;
  logic [WID_W-1:0]  width_q, width_d;
  logic [NEXT_W-1:0] prev_q, prev_d;
  logic              done_q, done_d, err_q, err_d;
  logic [CODE_W-1:0] idx_q, idx_d, code_q, code_d;
  logic [PW-1:0]     pos_q, pos_d;
  logic              kwk_q, kwk_d, add_q, add_d;
  logic [7:0]        first_q, first_d;
  logic              otv_q, otv_d;
  logic [7:0]        otd_q, otd_d;
  logic [3:0]        otu_q, otu_d;

  logic [3:0]        eff;
  logic [NEXT_W-1:0] clr, endc, code13, idx13, nidx13;
  logic              s_acc;
  bb_ctrl_t          bb_ctrl;
  bb_stat_t          bb_stat;

  logic              emit, emit_valid;
  logic [2:0]        emit_status;
  logic [7:0]        emit_byte;

  logic [CODE_W+7:0] dict_mem [DICT_ENTRIES];
  logic              dict_we, dict_re;
  logic [AW-1:0]     dict_waddr, dict_raddr;
  logic [CODE_W+7:0] dict_wdata, dict_rdata_q;
  logic [7:0]        stk_mem [DICT_ENTRIES];
  logic              stk_we, stk_re;
  logic [AW-1:0]     stk_waddr, stk_raddr;
  logic [7:0]        stk_wdata, stk_rdata_q;

  logic [CODE_W-1:0] nidx;
  logic [PW-1:0]     npos;
  logic [NEXT_W-1:0] next_inc;

  gld_bit_unpack u_unpack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (bb_ctrl),
    .byte_i  (s_axis_tdata),
    .width_i (width_q),
    .stat_o  (bb_stat)
  );

  assign eff    = (mcs_q < 4'd2) ? 4'd2 : ((mcs_q > 4'd8) ? 4'd8 : mcs_q);
  assign clr    = NEXT_W'(1) << eff;
  assign endc   = clr + NEXT_W'(1);
  assign code13 = NEXT_W'(bb_stat.code);
  assign idx13  = NEXT_W'(idx_q);
  assign nidx   = dict_rdata_q[CODE_W+7:8];
  assign nidx13 = NEXT_W'(nidx);
  assign npos   = pos_q + PW'(1);
  assign next_inc = next_q + NEXT_W'(1);

  assign s_axis_tready = (state_q == S_IDLE) && (!otv_q || m_axis_tready);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = otv_q;
  assign m_axis_tdata  = otd_q;
  assign m_axis_tuser  = otu_q;

  always_comb begin
    state_d    = state_q;
    stk_cnt_d  = stk_cnt_q;
    next_d     = next_q;
    width_d    = width_q;
    prev_d     = prev_q;
    done_d     = done_q;
    err_d      = err_q;
    idx_d      = idx_q;
    code_d     = code_q;
    pos_d      = pos_q;
    kwk_d      = kwk_q;
    add_d      = add_q;
    first_d    = first_q;
    bb_ctrl    = '0;
    dict_we    = 1'b0;
    dict_waddr = next_q[AW-1:0];
    dict_wdata = {prev_q[CODE_W-1:0], first_q};
    dict_re    = 1'b0;
    dict_raddr = idx_q[AW-1:0];
    stk_we     = 1'b0;
    stk_waddr  = pos_q[AW-1:0];
    stk_wdata  = '0;
    stk_re     = 1'b0;
    stk_raddr  = pos_q[AW-1:0] - AW'(1);
    emit        = 1'b0;
    emit_status = ST_OK;
    emit_valid  = 1'b0;
    emit_byte   = '0;

    case (state_q)
      S_IDLE: begin
        if (s_acc) begin
          case (s_axis_tuser)
            OP_FEED: begin
              emit = 1'b1;
              if (err_q) emit_status = ST_ERR;
              else if (done_q) emit_status = ST_DONE;
              else if (bb_stat.has_code || stk_cnt_q != '0) emit_status = ST_BUSY;
              else bb_ctrl.feed = 1'b1;
            end
            OP_PULL: begin
              if (stk_cnt_q != '0) begin
                stk_re    = 1'b1;
                stk_raddr = stk_cnt_q[AW-1:0] - AW'(1);
                stk_cnt_d = stk_cnt_q - PW'(1);
                state_d   = S_POP;
              end else if (err_q) begin
                emit = 1'b1;
                emit_status = ST_ERR;
              end else if (done_q) begin
                emit = 1'b1;
                emit_status = ST_DONE;
              end else begin
                state_d = S_DEC;
              end
            end
            OP_START: begin
              emit          = 1'b1;
              bb_ctrl.clear = 1'b1;
              stk_cnt_d     = '0;
              done_d        = 1'b0;
              err_d         = 1'b0;
              width_d       = eff + 4'd1;
              next_d        = clr + NEXT_W'(2);
              prev_d        = PREV_NONE;
            end
            default: emit = 1'b1;
          endcase
        end
      end

      S_DEC: begin
        if (!bb_stat.has_code) begin
          emit        = 1'b1;
          emit_status = ST_MORE;
          state_d     = S_IDLE;
        end else begin
          bb_ctrl.consume = 1'b1;
          code_d = bb_stat.code;
          if (code13 == clr) begin
            width_d = eff + 4'd1;
            next_d  = clr + NEXT_W'(2);
            prev_d  = PREV_NONE;
          end else if (code13 == endc) begin
            done_d      = 1'b1;
            emit        = 1'b1;
            emit_status = ST_DONE;
            state_d     = S_IDLE;
          end else if (code13 >= next_q) begin
            // code not yet in the table: previous string plus its first byte
            if (prev_q == PREV_NONE || prev_q >= next_q || next_q >= DICT_N) begin
              err_d = 1'b1; stk_cnt_d = '0;
              emit = 1'b1; emit_status = ST_ERR; state_d = S_IDLE;
            end else begin
              kwk_d = 1'b1; add_d = 1'b1;
              idx_d = prev_q[CODE_W-1:0];
              pos_d = PW'(1);
              state_d = S_WI;
            end
          end else begin
            if (prev_q != PREV_NONE && (prev_q >= next_q || next_q >= DICT_N)) begin
              err_d = 1'b1; stk_cnt_d = '0;
              emit = 1'b1; emit_status = ST_ERR; state_d = S_IDLE;
            end else begin
              kwk_d = 1'b0;
              add_d = (prev_q != PREV_NONE);
              idx_d = bb_stat.code;
              pos_d = '0;
              state_d = S_WI;
            end
          end
        end
      end

      S_WI: begin
        if (pos_q >= DICT_P) begin
          state_d = S_FIN;
        end else if (idx13 < clr) begin
          stk_we = 1'b1; stk_wdata = idx_q[7:0];
          first_d = idx_q[7:0]; pos_d = npos; state_d = S_FIN;
        end else if (idx13 >= DICT_N) begin
          stk_we = 1'b1; stk_wdata = '0;
          first_d = '0; pos_d = npos; state_d = S_FIN;
        end else begin
          dict_re = 1'b1;
          state_d = S_WD;
        end
      end

      S_WD: begin
        stk_we    = 1'b1;
        stk_wdata = dict_rdata_q[7:0];
        first_d   = dict_rdata_q[7:0];
        pos_d     = npos;
        idx_d     = nidx;
        // chain straight into the next entry while the walk stays inside
        if (npos < DICT_P && nidx13 >= clr && nidx13 < DICT_N) begin
          dict_re    = 1'b1;
          dict_raddr = nidx[AW-1:0];
        end else begin
          state_d = S_WI;
        end
      end

      S_FIN: begin
        stk_cnt_d = pos_q - PW'(1);
        if (kwk_q) begin
          stk_we    = 1'b1;
          stk_waddr = '0;
          stk_wdata = first_q;
        end
        if (add_q) begin
          dict_we = 1'b1;
          next_d  = next_inc;
          if (width_q < WID_W'(MAX_CODE_BITS) && next_inc >= (NEXT_W'(1) << width_q))
            width_d = width_q + WID_W'(1);
        end
        prev_d  = kwk_q ? next_q : NEXT_W'(code_q);
        stk_re  = 1'b1;
        state_d = S_POP;
      end

      S_POP: begin
        emit       = 1'b1;
        emit_valid = 1'b1;
        emit_byte  = stk_rdata_q;
        state_d    = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase

    otv_d = otv_q;
    otd_d = otd_q;
    otu_d = otu_q;
    if (emit) begin
      otv_d = 1'b1;
      otd_d = emit_byte;
      otu_d = {emit_valid, emit_status};
    end else if (m_axis_tready) begin
      otv_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mcs_q     <= MCS_RESET;
      state_q   <= S_IDLE;
      stk_cnt_q <= '0;
      next_q    <= (NEXT_W'(1) << MCS_RESET) + NEXT_W'(2);
      width_q   <= MCS_RESET + 4'd1;
      prev_q    <= PREV_NONE;
      done_q    <= 1'b0;
      err_q     <= 1'b0;
      kwk_q     <= 1'b0;
      add_q     <= 1'b0;
      otv_q     <= 1'b0;
    end else begin
      if (cfg_we_i) mcs_q <= cfg_wdata_i;
      state_q   <= state_d;
      stk_cnt_q <= stk_cnt_d;
      next_q    <= next_d;
      width_q   <= width_d;
      prev_q    <= prev_d;
      done_q    <= done_d;
      err_q     <= err_d;
      kwk_q     <= kwk_d;
      add_q     <= add_d;
      otv_q     <= otv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    code_q  <= code_d;
    pos_q   <= pos_d;
    first_q <= first_d;
    otd_q   <= otd_d;
    otu_q   <= otu_d;
  end

  always_ff @(posedge clk_i) begin
    if (dict_we) dict_mem[dict_waddr] <= dict_wdata;
    if (dict_re) dict_rdata_q <= dict_mem[dict_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) stk_mem[stk_waddr] <= stk_wdata;
    if (stk_re) stk_rdata_q <= stk_mem[stk_raddr];
  end

  `GLD_ASSERT(a_stack_bound, clk_i, rst_ni, stk_cnt_q <= DICT_P)
  `GLD_ASSERT(a_err_empty, clk_i, rst_ni, (err_q && state_q == S_IDLE) |-> stk_cnt_q == '0)
  `GLD_ASSERT(a_width_range, clk_i, rst_ni,
    width_q >= WID_W'(3) && width_q <= WID_W'(MAX_CODE_BITS))
  `GLD_ASSERT_ALWAYS(a_byte_ok, clk_i, (otv_q && otu_q[3]) |-> otu_q[2:0] == ST_OK)

endmodule
